// File: hw/rtl/vwwa_pkg.sv
// Package with shared types and constants of the variable window weighted average.
`default_nettype none
package vwwa_pkg;

  localparam int ROWS_DEF       = 64;
  localparam int COLS_DEF       = 64;
  localparam int MAX_RADIUS_DEF = 7;

  // Operation codes of an input word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Window size 1.0 in Q8.8 and one full axis weight (units of 1/512).
  localparam logic [15:0] ONE_CELL  = 16'd256;
  localparam logic [9:0]  FULL_AXIS = 10'd512;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               operation;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] cell_value;
    logic               cell_present;
    logic [15:0]        window_cells;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] average_value;
    logic               average_present;
    logic               radius_clipped;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/vwwa_ram.sv
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module vwwa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/variable_window_weighted_average.sv
// Top level of the variable window weighted average over a raster cell store.
//
//   Channel  Ports                    Handshake
//   input    start, busy, in_item     word taken when start is high and busy is low
//   result   out_valid, out_item      word shown for one cycle, taken at its end
//
// A load is written into the cell RAM as it is taken. A query scans the (2R+1)^2 window
// one cell per cycle through the cell RAM read port, drains the pipeline, divides in the
// bit-serial divider and shows its result; with no present cell it skips the division.
// After reset the store is cleared one cell per cycle, all ROWS*COLS cells, with busy high.
// The receiver cannot stall; each result is shown exactly once.
`default_nettype none
module variable_window_weighted_average
  import vwwa_pkg::*;
#(
  parameter int ROWS       = ROWS_DEF,
  parameter int COLS       = COLS_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  state_t state_r, state_nxt;

  // Control registers.
  logic [AW-1:0]      clr_r;
  logic [1:0]         drn_r;
  logic [5:0]         it_r;
  logic               out_valid_r;
  out_item_t          out_r;

  // Query setup and scan counters.
  logic [5:0]         qr_r, qc_r;
  logic [5:0]         rad_r;
  logic [8:0]         frac_r;
  logic               clip_r;
  logic signed [6:0]  dr_r, dc_r;

  // Pipeline and accumulators.
  logic               s1_vld_r;
  logic [18:0]        s1_w_r;
  logic               p_vld_r;
  logic signed [51:0] prod_r;
  logic [18:0]        p_w_r;
  logic signed [63:0] total_r;
  logic [31:0]        count_r;

  // Divider registers.
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r;
  logic               neg_r;

  logic               accept;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [32:0]        mem_wdata, mem_rdata;

  assign accept = start && !busy;

  // Setup of the window geometry from the query word.
  logic [15:0] h_w;
  logic [7:0]  rad_full;
  logic        clip_w;
  always_comb begin
    h_w      = in_item.window_cells - ONE_CELL;
    rad_full = 8'((17'(h_w) + 17'd511) >> 9);
    clip_w   = (in_item.window_cells > ONE_CELL) && (rad_full > 8'(MAX_RADIUS));
  end

  // Scan address generation and per-cell weight.
  logic signed [11:0] r_s, c_s;
  logic               in_rng;
  logic [9:0]         wr_ax, wc_ax;
  logic [6:0]         ar, ac;
  logic               last_cell;
  always_comb begin
    r_s    = 12'(signed'({1'b0, qr_r})) + 12'(dr_r);
    c_s    = 12'(signed'({1'b0, qc_r})) + 12'(dc_r);
    in_rng = (r_s >= 0) && (r_s < 12'(ROWS)) && (c_s >= 0) && (c_s < 12'(COLS));
    ar     = dr_r[6] ? 7'(-dr_r) : 7'(dr_r);
    ac     = dc_r[6] ? 7'(-dc_r) : 7'(dc_r);
    wr_ax  = (frac_r != 9'd0 && ar == {1'b0, rad_r}) ? {1'b0, frac_r} : FULL_AXIS;
    wc_ax  = (frac_r != 9'd0 && ac == {1'b0, rad_r}) ? {1'b0, frac_r} : FULL_AXIS;
    mem_raddr = AW'(int'(r_s[10:0]) * COLS + int'(c_s[10:0]));
    last_cell = (dr_r == 7'(signed'({1'b0, rad_r}))) && (dc_r == 7'(signed'({1'b0, rad_r})));
  end

  // Divider step and final dividend.
  logic [32:0] trial;
  logic        qbit;
  logic [63:0] mag;
  always_comb begin
    trial = {rem_r, dvd_r[63]};
    qbit  = trial >= {1'b0, count_r};
    mag   = total_r[63] ? 64'(-total_r) : 64'(total_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && in_item.operation == OP_QUERY && in_item.window_cells != 16'd0) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:  if (last_cell) state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (drn_r == 2'd2) state_nxt = (count_r == 32'd0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV:   if (it_r == 6'd63) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    unique case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        mem_waddr = AW'(int'(in_item.row) * COLS + int'(in_item.col));
        mem_wdata = {in_item.cell_present, in_item.cell_value};
        mem_we    = accept && in_item.operation == OP_LOAD &&
                    (int'(in_item.row) < ROWS) && (int'(in_item.col) < COLS);
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      drn_r       <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      p_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      drn_r    <= (state_r == ST_DRAIN) ? drn_r + 2'd1 : 2'd0;
      it_r     <= (state_r == ST_DIV) ? it_r + 6'd1 : 6'd0;
      s1_vld_r <= (state_r == ST_SCAN) && in_rng;
      p_vld_r  <= s1_vld_r && mem_rdata[32];
      if (state_r == ST_IDLE && accept && in_item.operation == OP_QUERY &&
          in_item.window_cells == 16'd0) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_DRAIN && drn_r == 2'd2 && count_r == 32'd0) out_valid_r <= 1'b1;
      if (state_r == ST_DONE) out_valid_r <= 1'b1;
    end
  end

  // Datapath: setup, scan pipeline, accumulation, division.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      qr_r    <= in_item.row;
      qc_r    <= in_item.col;
      clip_r  <= clip_w;
      total_r <= '0;
      count_r <= '0;
      if (in_item.window_cells <= ONE_CELL) begin
        rad_r  <= '0;
        frac_r <= '0;
      end else if (clip_w) begin
        rad_r  <= 6'(MAX_RADIUS);
        frac_r <= '0;
      end else begin
        rad_r  <= rad_full[5:0];
        frac_r <= h_w[8:0];
      end
      out_r.average_value   <= '0;
      out_r.average_present <= 1'b0;
      out_r.radius_clipped  <= 1'b0;
      dr_r <= in_item.window_cells <= ONE_CELL ? 7'sd0 :
              clip_w ? 7'(-MAX_RADIUS) : -7'(signed'({1'b0, rad_full[5:0]}));
      dc_r <= in_item.window_cells <= ONE_CELL ? 7'sd0 :
              clip_w ? 7'(-MAX_RADIUS) : -7'(signed'({1'b0, rad_full[5:0]}));
    end
    if (state_r == ST_SCAN) begin
      if (dc_r == 7'(signed'({1'b0, rad_r}))) begin
        dc_r <= -7'(signed'({1'b0, rad_r}));
        dr_r <= dr_r + 7'sd1;
      end else begin
        dc_r <= dc_r + 7'sd1;
      end
    end
    s1_w_r <= 19'(wr_ax) * 19'(wc_ax);
    prod_r <= 52'(signed'(mem_rdata[31:0])) * 52'(signed'({1'b0, s1_w_r}));
    p_w_r  <= s1_w_r;
    if (p_vld_r && state_r != ST_IDLE) begin
      total_r <= total_r + 64'(prod_r);
      count_r <= count_r + 32'(p_w_r);
    end
    if (state_r == ST_DRAIN && drn_r == 2'd2) begin
      neg_r <= total_r[63];
      dvd_r <= mag + 64'(count_r >> 1);
      rem_r <= '0;
      out_r.radius_clipped <= clip_r;
    end
    if (state_r == ST_DIV) begin
      rem_r <= qbit ? 32'(trial - {1'b0, count_r}) : trial[31:0];
      dvd_r <= {dvd_r[62:0], qbit};
    end
    if (state_r == ST_DONE) begin
      out_r.average_value   <= neg_r ? 32'(-dvd_r) : dvd_r[31:0];
      out_r.average_present <= 1'b1;
    end
  end

  // Cell store.
  vwwa_ram #(
    .WIDTH(33),
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_cells (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// File: tb/vwwa_checker.sv
// Checker that predicts and compares the results of the variable window weighted average.
module vwwa_checker
  import vwwa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire out_item_t out_item,
  output int             fail_count,
  output int             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS  = 64;
  localparam int NCOLS  = 64;
  localparam int RAD_MAX = 7;

  logic signed [31:0] raster_value [NROWS*NCOLS];
  logic               raster_present [NROWS*NCOLS];
  out_item_t          average_queue [$];

  // Axis weight in units of 1/512.
  function automatic longint axis_wt(int d, int radius, int frac);
    int a;
    a = d < 0 ? -d : d;
    if (frac != 0 && a == radius) return frac;
    return 512;
  endfunction

  // Expected result of one query word against the current raster.
  function automatic out_item_t window_average(in_item_t w);
    out_item_t res;
    int radius, frac, r, c, h;
    longint total, count, wt, mag, q;
    logic neg;
    res = '0;
    total = 0;
    count = 0;
    if (w.window_cells == 16'd0) return res;
    if (w.window_cells <= ONE_CELL) begin
      radius = 0;
      frac = 0;
    end else begin
      h = int'(w.window_cells) - 256;
      radius = (h + 511) >>> 9;
      frac = h & 511;
      if (radius > RAD_MAX) begin
        radius = RAD_MAX;
        frac = 0;
        res.radius_clipped = 1'b1;
      end
    end
    for (int dr = -radius; dr <= radius; dr++) begin
      r = int'(w.row) + dr;
      if (r < 0 || r >= NROWS) continue;
      for (int dc = -radius; dc <= radius; dc++) begin
        c = int'(w.col) + dc;
        if (c < 0 || c >= NCOLS || !raster_present[r*NCOLS+c]) continue;
        wt = axis_wt(dr, radius, frac) * axis_wt(dc, radius, frac);
        total += longint'(raster_value[r*NCOLS+c]) * wt;
        count += wt;
      end
    end
    if (count > 0) begin
      neg = total < 0;
      mag = neg ? -total : total;
      q = (mag + count / 2) / count;
      res.average_value = 32'(neg ? -q : q);
      res.average_present = 1'b1;
    end
    return res;
  endfunction

  assign pending_count = average_queue.size();

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      foreach (raster_present[i]) begin
        raster_present[i] <= 1'b0;
        raster_value[i] <= '0;
      end
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (average_queue.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result word: %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = average_queue.pop_front();
          if (exp_item !== out_item) begin
            if (fail_count < 10)
              $display("Mismatch: expected value %0d present %0b clipped %0b, got %0d %0b %0b",
                       exp_item.average_value, exp_item.average_present,
                       exp_item.radius_clipped, out_item.average_value,
                       out_item.average_present, out_item.radius_clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_item.operation == OP_LOAD) begin
          raster_value[in_item.row*NCOLS+in_item.col] = in_item.cell_value;
          raster_present[in_item.row*NCOLS+in_item.col] = in_item.cell_present;
        end else begin
          average_queue.push_back(window_average(in_item));
        end
      end
    end
  end
endmodule

// File: tb/tb_variable_window_weighted_average.sv
// Testbench top: stimulus, clock, reset and final verdict for the window average.
module tb_variable_window_weighted_average;
  import vwwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending_count;
  int        idle_cycles = 0;
  bit        idle_enable = 1'b1;

  always #5 clk = ~clk;

  variable_window_weighted_average dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  vwwa_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Watchdog on cycles without any accepted word or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one word and hold it until taken, with an optional gap before.
  task automatic send_word(in_item_t w);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_cell(int r, int c, logic [31:0] v, logic p);
    in_item_t w;
    w = '0;
    w.operation = OP_LOAD;
    w.row = 6'(r);
    w.col = 6'(c);
    w.cell_value = v;
    w.cell_present = p;
    send_word(w);
  endtask

  task automatic query_cell(int r, int c, logic [15:0] s);
    in_item_t w;
    w = '0;
    w.cell_present = 1'($urandom());
    w.cell_value = $urandom();
    w.operation = OP_QUERY;
    w.row = 6'(r);
    w.col = 6'(c);
    w.window_cells = s;
    send_word(w);
  endtask

  // Random cell near a small cluster so windows hit loaded data, else anywhere.
  function automatic int pick_index(int hot);
    if ($urandom_range(0, 3) != 0) return hot + $urandom_range(0, 8) - 4;
    return $urandom_range(0, 63);
  endfunction

  initial begin
    int hr, hc, r, c;
    logic [15:0] s;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extremes, windows of every kind.
    query_cell(0, 0, 16'd256);
    query_cell(10, 10, 16'd0);
    load_cell(0, 0, 32'h7fffffff, 1'b1);
    load_cell(0, 1, 32'h80000000, 1'b1);
    load_cell(63, 63, 32'hffffffff, 1'b1);
    load_cell(63, 62, 32'h00010000, 1'b0);
    load_cell(1, 0, 32'h00018000, 1'b1);
    query_cell(0, 0, 16'd1);
    query_cell(0, 0, 16'd256);
    query_cell(0, 0, 16'd257);
    query_cell(0, 0, 16'd512);
    query_cell(0, 1, 16'd768);
    query_cell(63, 63, 16'd1000);
    query_cell(63, 62, 16'd256);
    query_cell(32, 32, 16'd3000);
    query_cell(0, 0, 16'd4096);
    query_cell(1, 1, 16'hffff);
    query_cell(62, 62, 16'd7424);
    query_cell(62, 62, 16'd7425);
    load_cell(0, 0, 32'h0, 1'b0);
    query_cell(0, 0, 16'd256);

    // Random loads and queries around moving hot spots.
    for (int i = 0; i < 1500; i++) begin
      if (i % 100 == 0) begin
        hr = $urandom_range(0, 63);
        hc = $urandom_range(0, 63);
      end
      if (i > 1350) idle_enable = 1'b0;
      r = pick_index(hr);
      c = pick_index(hc);
      if (r < 0) r = 0;
      if (r > 63) r = 63;
      if (c < 0) c = 0;
      if (c > 63) c = 63;
      if ($urandom_range(0, 2) != 0) begin
        load_cell(r, c, $urandom(), $urandom_range(0, 4) != 0);
      end else begin
        case ($urandom_range(0, 3))
          0: s = 16'($urandom_range(0, 256));
          1: s = 16'($urandom_range(257, 2048));
          2: s = 16'($urandom_range(2049, 7680));
          default: s = 16'($urandom());
        endcase
        query_cell(r, c, s);
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
